@@ hdl/inct_pkg.sv @@
// ----------------------------------------------------------------------------
// Nesting completeness tracker package
// Shared constants, character codes and types for the tracker and its
// next-state logic.
// ----------------------------------------------------------------------------
package inct_pkg;

    // Default width of each nesting counter.
    localparam int unsigned LEVEL_WIDTH_DEFAULT = 8;

    // Width of the level fields on the result channel.
    localparam int unsigned LEVEL_OUT_WIDTH = 8;

    // Command codes.
    localparam logic CMD_CONSUME = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    // Comment kind codes reported on the result channel.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_PAREN = 2'd2;

    // Character codes that the tracker reacts to.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    // Lexical mode flags.
    typedef struct packed {
        logic quoted;
        logic escape;
        logic line_cmt;
        logic paren_cmt;
    } inct_flags_t;

    localparam inct_flags_t FLAGS_CLEAR = '{
        quoted:    1'b0,
        escape:    1'b0,
        line_cmt:  1'b0,
        paren_cmt: 1'b0
    };

endpackage

@@ hdl/inct_next_state.sv @@
// ----------------------------------------------------------------------------
// Nesting completeness tracker: next-state logic
// Works out the counters and flags after one character or clear command,
// together with the complete flag and comment kind of the new state.
// ----------------------------------------------------------------------------
module inct_next_state
    import inct_pkg::*;
#(
    parameter int unsigned LEVEL_WIDTH = LEVEL_WIDTH_DEFAULT
)
(
    input  logic                   command,
    input  logic [7:0]             character,
    input  logic [LEVEL_WIDTH-1:0] bracket_cur,
    input  logic [LEVEL_WIDTH-1:0] brace_cur,
    input  logic [LEVEL_WIDTH-1:0] colon_cur,
    input  inct_flags_t            flags_cur,
    output logic [LEVEL_WIDTH-1:0] bracket_nxt,
    output logic [LEVEL_WIDTH-1:0] brace_nxt,
    output logic [LEVEL_WIDTH-1:0] colon_nxt,
    output inct_flags_t            flags_nxt,
    output logic                   complete_nxt,
    output logic [1:0]             kind_nxt
);

    localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX  = {LEVEL_WIDTH{1'b1}};
    localparam logic [LEVEL_WIDTH-1:0] LEVEL_ZERO = '0;
    localparam logic [LEVEL_WIDTH-1:0] LEVEL_ONE  = LEVEL_WIDTH'(1);

    logic [LEVEL_WIDTH-1:0] bracket_up;
    logic [LEVEL_WIDTH-1:0] bracket_dn;
    logic [LEVEL_WIDTH-1:0] brace_up;
    logic [LEVEL_WIDTH-1:0] brace_dn;
    logic [LEVEL_WIDTH-1:0] colon_up;
    logic [LEVEL_WIDTH-1:0] colon_dn;

    // Saturating increments that stop at the maximum and decrements that stop at zero.
    assign bracket_up = (bracket_cur == LEVEL_MAX)  ? bracket_cur : bracket_cur + LEVEL_ONE;
    assign bracket_dn = (bracket_cur == LEVEL_ZERO) ? bracket_cur : bracket_cur - LEVEL_ONE;
    assign brace_up   = (brace_cur == LEVEL_MAX)    ? brace_cur   : brace_cur + LEVEL_ONE;
    assign brace_dn   = (brace_cur == LEVEL_ZERO)   ? brace_cur   : brace_cur - LEVEL_ONE;
    assign colon_up   = (colon_cur == LEVEL_MAX)    ? colon_cur   : colon_cur + LEVEL_ONE;
    assign colon_dn   = (colon_cur == LEVEL_ZERO)   ? colon_cur   : colon_cur - LEVEL_ONE;

    // Character rules: clear command first, then comments, then strings, then plain source.
    always_comb
    begin
        bracket_nxt = bracket_cur;
        brace_nxt   = brace_cur;
        colon_nxt   = colon_cur;
        flags_nxt   = flags_cur;
        if (command == CMD_CLEAR)
        begin
            bracket_nxt = LEVEL_ZERO;
            brace_nxt   = LEVEL_ZERO;
            colon_nxt   = LEVEL_ZERO;
            flags_nxt   = FLAGS_CLEAR;
        end
        else if (flags_cur.line_cmt)
        begin
            if (character == CH_NEWLINE)
            begin
                flags_nxt.line_cmt = 1'b0;
            end
        end
        else if (flags_cur.paren_cmt)
        begin
            if (character == CH_RPAREN)
            begin
                flags_nxt.paren_cmt = 1'b0;
            end
        end
        else if (flags_cur.quoted)
        begin
            if (flags_cur.escape)
            begin
                flags_nxt.escape = 1'b0;
            end
            else if (character == CH_BACKSLASH)
            begin
                flags_nxt.escape = 1'b1;
            end
            else if (character == CH_QUOTE)
            begin
                flags_nxt.quoted = 1'b0;
            end
        end
        else
        begin
            unique case (character)
                CH_BACKSLASH: flags_nxt.line_cmt  = 1'b1;
                CH_LPAREN:    flags_nxt.paren_cmt = 1'b1;
                CH_QUOTE:     flags_nxt.quoted    = 1'b1;
                CH_LBRACKET:  bracket_nxt = bracket_up;
                CH_RBRACKET:  bracket_nxt = bracket_dn;
                CH_LBRACE:    brace_nxt   = brace_up;
                CH_RBRACE:    brace_nxt   = brace_dn;
                CH_COLON:     colon_nxt   = colon_up;
                CH_SEMICOLON: colon_nxt   = colon_dn;
                default:      ;
            endcase
        end
    end

    // Status of the new state.
    assign complete_nxt = (flags_nxt == FLAGS_CLEAR) && (bracket_nxt == LEVEL_ZERO) &&
                          (brace_nxt == LEVEL_ZERO) && (colon_nxt == LEVEL_ZERO);
    assign kind_nxt = flags_nxt.line_cmt  ? KIND_LINE  :
                      flags_nxt.paren_cmt ? KIND_PAREN : KIND_NONE;

endmodule

@@ hdl/input_nesting_completeness_tracker.sv @@
// ----------------------------------------------------------------------------
// Input nesting completeness tracker
// Follows square-bracket, brace and colon-definition nesting plus string
// and comment modes over a stream of source characters, and reports after
// each character whether the source so far is complete.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   command, character
//   output   out_valid / out_ready complete, block_level, brace_level,
//                                  definition_level, inside_string,
//                                  comment_kind
//
// Each transfer passes through an input register, then the state update,
// which loads the result register.
// One character is accepted every cycle while the output is not stalled;
// the throughput is set by the combinational update of the counters and flags.
// Reset clears all counters and flags; the clear command does the same.
// A stalled output holds the result and the input register, and in_ready
// drops only while both stages are full.
// ----------------------------------------------------------------------------
module input_nesting_completeness_tracker
    import inct_pkg::*;
#(
    parameter int unsigned LEVEL_WIDTH = LEVEL_WIDTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] character,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       complete,
    output logic [7:0] block_level,
    output logic [7:0] brace_level,
    output logic [7:0] definition_level,
    output logic       inside_string,
    output logic [1:0] comment_kind
);

    // Input register.
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_command_reg;
    logic [7:0]             s1_char_reg;

    // Tracker state.
    logic [LEVEL_WIDTH-1:0] bracket_reg;
    logic [LEVEL_WIDTH-1:0] brace_reg;
    logic [LEVEL_WIDTH-1:0] colon_reg;
    inct_flags_t            flags_reg;
    logic [LEVEL_WIDTH-1:0] bracket_next;
    logic [LEVEL_WIDTH-1:0] brace_next;
    logic [LEVEL_WIDTH-1:0] colon_next;
    inct_flags_t            flags_next;
    logic                   complete_next;
    logic [1:0]             kind_next;

    // Result register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   complete_reg;
    logic [LEVEL_OUT_WIDTH-1:0] block_level_reg;
    logic [LEVEL_OUT_WIDTH-1:0] brace_level_reg;
    logic [LEVEL_OUT_WIDTH-1:0] definition_level_reg;
    logic                   inside_string_reg;
    logic [1:0]             comment_kind_reg;
    logic [LEVEL_OUT_WIDTH-1:0] block_level_next;
    logic [LEVEL_OUT_WIDTH-1:0] brace_level_next;
    logic [LEVEL_OUT_WIDTH-1:0] definition_level_next;

    logic                   in_xfer;
    logic                   s1_advance;
    logic                   out_free;

    // Handshake control.
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || out_free;
    assign in_xfer    = in_valid && in_ready;

    assign s1_valid_next  = in_xfer || (s1_valid_reg && !s1_advance);
    assign out_valid_next = s1_advance || (out_valid_reg && !out_ready);

    // State update for the character held in the input register.
    inct_next_state #(
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_next_state (
        .command      (s1_command_reg),
        .character    (s1_char_reg),
        .bracket_cur  (bracket_reg),
        .brace_cur    (brace_reg),
        .colon_cur    (colon_reg),
        .flags_cur    (flags_reg),
        .bracket_nxt  (bracket_next),
        .brace_nxt    (brace_next),
        .colon_nxt    (colon_next),
        .flags_nxt    (flags_next),
        .complete_nxt (complete_next),
        .kind_nxt     (kind_next)
    );

    // The level fields carry the low bits of each counter, zero-extended when the counter is narrower.
    generate
        if (LEVEL_WIDTH >= LEVEL_OUT_WIDTH)
        begin : g_level_trunc
            assign block_level_next      = bracket_next[LEVEL_OUT_WIDTH-1:0];
            assign brace_level_next      = brace_next[LEVEL_OUT_WIDTH-1:0];
            assign definition_level_next = colon_next[LEVEL_OUT_WIDTH-1:0];
        end
        else
        begin : g_level_ext
            assign block_level_next      = {{(LEVEL_OUT_WIDTH-LEVEL_WIDTH){1'b0}}, bracket_next};
            assign brace_level_next      = {{(LEVEL_OUT_WIDTH-LEVEL_WIDTH){1'b0}}, brace_next};
            assign definition_level_next = {{(LEVEL_OUT_WIDTH-LEVEL_WIDTH){1'b0}}, colon_next};
        end
    endgenerate

    // Valid bits and tracker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bracket_reg   <= '0;
            brace_reg     <= '0;
            colon_reg     <= '0;
            flags_reg     <= FLAGS_CLEAR;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                bracket_reg <= bracket_next;
                brace_reg   <= brace_next;
                colon_reg   <= colon_next;
                flags_reg   <= flags_next;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_command_reg <= command;
            s1_char_reg    <= character;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            complete_reg         <= complete_next;
            block_level_reg      <= block_level_next;
            brace_level_reg      <= brace_level_next;
            definition_level_reg <= definition_level_next;
            inside_string_reg    <= flags_next.quoted;
            comment_kind_reg     <= kind_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign complete         = complete_reg;
    assign block_level      = block_level_reg;
    assign brace_level      = brace_level_reg;
    assign definition_level = definition_level_reg;
    assign inside_string    = inside_string_reg;
    assign comment_kind     = comment_kind_reg;

    // The two comment modes exclude each other.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(flags_reg.line_cmt && flags_reg.paren_cmt))
    else $error("line and parenthesis comment both active");

    // An escape is only pending inside a string.
    assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.escape |-> flags_reg.quoted)
    else $error("escape pending outside a string");

    // A clear command always yields a complete result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_command_reg == CMD_CLEAR) |=> (out_valid && complete))
    else $error("clear command did not give a complete result");

    // A complete result shows no string and no comment.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && complete) |-> (!inside_string && comment_kind == KIND_NONE))
    else $error("complete reported inside a string or comment");

endmodule
